### src/bttseq_pkg.sv
`timescale 1ns / 1ps

package bttseq_pkg;

   localparam logic [1:0] OP_BUTTON  = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_STARTUP = 2'd2;

   localparam logic [2:0] SEL_D5      = 3'd0;
   localparam logic [2:0] SEL_B2      = 3'd1;
   localparam logic [2:0] SEL_B3      = 3'd2;
   localparam logic [2:0] SEL_AS5     = 3'd3;
   localparam logic [2:0] SEL_F3      = 3'd4;
   localparam logic [2:0] SEL_CHIME   = 3'd5;
   localparam logic [2:0] SEL_STARTUP = 3'd6;

   localparam logic [7:0] BTN_D5    = 8'd254;
   localparam logic [7:0] BTN_B2    = 8'd253;
   localparam logic [7:0] BTN_B3    = 8'd251;
   localparam logic [7:0] BTN_AS5   = 8'd247;
   localparam logic [7:0] BTN_F3    = 8'd239;
   localparam logic [7:0] BTN_CHIME = 8'd223;

   localparam logic [1:0] REG_D5  = 2'd0;
   localparam logic [1:0] REG_AS5 = 2'd1;
   localparam logic [1:0] REG_F3  = 2'd2;

   localparam int              CSR_ADDR_W  = 4;
   localparam int              CSR_DATA_W  = 32;
   localparam logic [15:0]     D5_RESET    = 16'd587;
   localparam logic [15:0]     AS5_RESET   = 16'd932;
   localparam logic [15:0]     F3_RESET    = 16'd175;
   localparam logic [11:0]     DAC_HIGH    = 12'hFFF;
   localparam int              MS_PER_S    = 1000;
   localparam logic [15:0]     RECIP5      = 16'd52429;
   localparam int              RECIP5_SHIFT = 18;

   typedef struct packed {
      logic [15:0] d5_hz;
      logic [15:0] as5_hz;
      logic [15:0] f3_hz;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  led_pattern;
      logic [11:0] dac_level;
      logic        dac_on;
      logic        timer_on;
      logic [15:0] tone_freq;
      logic        tone_load;
   } rsp_type;

   function automatic logic [2:0] tune_len(input logic [2:0] sel);
      logic [2:0] n;
      n = 3'd0;
      case (sel)
         SEL_D5, SEL_B2, SEL_B3, SEL_AS5, SEL_F3: n = 3'd1;
         SEL_CHIME:   n = 3'd5;
         SEL_STARTUP: n = 3'd7;
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [15:0] fixed_freq(input logic [2:0] sel, input logic [2:0] pos);
      logic [15:0] f;
      f = 16'd0;
      case (sel)
         SEL_B2, SEL_B3: begin
            if (pos == 3'd0) f = 16'd660;
         end
         SEL_CHIME: begin
            case (pos)
               3'd0:    f = 16'd660;
               3'd1:    f = 16'd330;
               3'd2:    f = 16'd165;
               3'd3:    f = 16'd500;
               3'd4:    f = 16'd100;
               default: f = 16'd0;
            endcase
         end
         SEL_STARTUP: begin
            case (pos)
               3'd0, 3'd6: f = 16'd400;
               3'd1, 3'd5: f = 16'd500;
               3'd2, 3'd4: f = 16'd600;
               3'd3:       f = 16'd700;
               default:    f = 16'd0;
            endcase
         end
         default: f = 16'd0;
      endcase
      return f;
   endfunction

   function automatic logic [15:0] fixed_ticks(input logic [2:0] sel, input logic [2:0] pos);
      logic [15:0] t;
      t = 16'd0;
      case (sel)
         SEL_B2, SEL_B3: begin
            if (pos == 3'd0) t = 16'(660 * 200 / MS_PER_S);
         end
         SEL_CHIME: begin
            case (pos)
               3'd0:    t = 16'(660 * 200 / MS_PER_S);
               3'd1:    t = 16'(330 * 200 / MS_PER_S);
               3'd2:    t = 16'(165 * 200 / MS_PER_S);
               3'd3:    t = 16'(500 * 200 / MS_PER_S);
               3'd4:    t = 16'(100 * 600 / MS_PER_S);
               default: t = 16'd0;
            endcase
         end
         SEL_STARTUP: begin
            case (pos)
               3'd0, 3'd6: t = 16'(400 * 200 / MS_PER_S);
               3'd1, 3'd5: t = 16'(500 * 200 / MS_PER_S);
               3'd2, 3'd4: t = 16'(600 * 200 / MS_PER_S);
               3'd3:       t = 16'(700 * 200 / MS_PER_S);
               default:    t = 16'd0;
            endcase
         end
         default: t = 16'd0;
      endcase
      return t;
   endfunction

endpackage

### src/bttseq_csr.sv
`timescale 1ns / 1ps

module bttseq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bttseq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bttseq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bttseq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                  pready,
   output bttseq_pkg::cfg_type                   cfg
);
   import bttseq_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_D5:  cfg_in.d5_hz  = pwdata[15:0];
            REG_AS5: cfg_in.as5_hz = pwdata[15:0];
            REG_F3:  cfg_in.f3_hz  = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_D5:  prdata = CSR_DATA_W'(cfg_ff.d5_hz);
         REG_AS5: prdata = CSR_DATA_W'(cfg_ff.as5_hz);
         REG_F3:  prdata = CSR_DATA_W'(cfg_ff.f3_hz);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.d5_hz  <= D5_RESET;
         cfg_ff.as5_hz <= AS5_RESET;
         cfg_ff.f3_hz  <= F3_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/bttseq_note.sv
`timescale 1ns / 1ps

module bttseq_note (
   input  bttseq_pkg::cfg_type cfg,
   input  logic [2:0]          sel,
   input  logic [2:0]          pos,
   output logic [15:0]         freq,
   output logic [15:0]         ticks
);
   import bttseq_pkg::*;

   logic        from_cfg;
   logic [15:0] cfg_freq;
   logic [17:0] scaled;
   logic [33:0] prod;
   logic [15:0] fifth;
   logic [15:0] raw_ticks;

   assign from_cfg = (pos == 3'd0) &&
                     (sel == SEL_D5 || sel == SEL_AS5 || sel == SEL_F3);

   always_comb begin
      case (sel)
         SEL_AS5: cfg_freq = cfg.as5_hz;
         SEL_F3:  cfg_freq = cfg.f3_hz;
         default: cfg_freq = cfg.d5_hz;
      endcase
   end

   // 150 ms F3 note: floor(3f/20) = floor(floor(3f/5)/4)
   assign scaled = (sel == SEL_F3) ? (18'(cfg_freq) + {1'b0, cfg_freq, 1'b0})
                                   : 18'(cfg_freq);
   assign prod   = 34'(scaled) * 34'(RECIP5);
   assign fifth  = prod[RECIP5_SHIFT +: 16];

   always_comb begin
      if (from_cfg) begin
         freq = cfg_freq;
         case (sel)
            SEL_AS5: raw_ticks = fifth >> 1;
            SEL_F3:  raw_ticks = fifth >> 2;
            default: raw_ticks = fifth;
         endcase
      end else begin
         freq      = fixed_freq(sel, pos);
         raw_ticks = fixed_ticks(sel, pos);
      end
   end

   assign ticks = (raw_ticks == 16'd0) ? 16'd1 : raw_ticks;

endmodule

### src/bttseq_player.sv
`timescale 1ns / 1ps

module bttseq_player (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          opcode,
   input  logic [7:0]          button_state,
   input  bttseq_pkg::cfg_type cfg,
   output bttseq_pkg::rsp_type result
);
   import bttseq_pkg::*;

   logic [2:0]  melody_sel_ff, melody_sel_in;
   logic [2:0]  note_pos_ff, note_pos_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] note_ticks_ff, note_ticks_in;
   logic        wave_high_next_ff, wave_high_next_in;
   logic        playing_ff, playing_in;
   logic [7:0]  led_ff, led_in;
   logic [11:0] dac_ff, dac_in;
   logic        dac_en_ff, dac_en_in;
   logic        timer_en_ff, timer_en_in;
   logic [15:0] tone_ff, tone_in;
   logic        load;

   logic        btn_hit;
   logic [2:0]  btn_sel;
   logic [2:0]  pos_next;
   logic [15:0] count_next;
   logic [2:0]  look_sel;
   logic [2:0]  look_pos;
   logic [15:0] look_freq;
   logic [15:0] look_ticks;

   always_comb begin
      btn_hit = 1'b1;
      case (button_state)
         BTN_D5:    btn_sel = SEL_D5;
         BTN_B2:    btn_sel = SEL_B2;
         BTN_B3:    btn_sel = SEL_B3;
         BTN_AS5:   btn_sel = SEL_AS5;
         BTN_F3:    btn_sel = SEL_F3;
         BTN_CHIME: btn_sel = SEL_CHIME;
         default: begin
            btn_hit = 1'b0;
            btn_sel = SEL_D5;
         end
      endcase
   end

   assign pos_next   = note_pos_ff + 3'd1;
   assign count_next = tick_count_ff + 16'd1;

   always_comb begin
      case (opcode)
         OP_BUTTON: begin
            look_sel = btn_sel;
            look_pos = 3'd0;
         end
         OP_STARTUP: begin
            look_sel = SEL_STARTUP;
            look_pos = 3'd0;
         end
         default: begin
            look_sel = melody_sel_ff;
            look_pos = pos_next;
         end
      endcase
   end

   bttseq_note u_note (
      .cfg   (cfg),
      .sel   (look_sel),
      .pos   (look_pos),
      .freq  (look_freq),
      .ticks (look_ticks)
   );

   always_comb begin
      melody_sel_in     = melody_sel_ff;
      note_pos_in       = note_pos_ff;
      tick_count_in     = tick_count_ff;
      note_ticks_in     = note_ticks_ff;
      wave_high_next_in = wave_high_next_ff;
      playing_in        = playing_ff;
      led_in            = led_ff;
      dac_in            = dac_ff;
      dac_en_in         = dac_en_ff;
      timer_en_in       = timer_en_ff;
      tone_in           = tone_ff;
      load              = 1'b0;
      case (opcode)
         OP_BUTTON, OP_STARTUP: begin
            dac_en_in = 1'b1;
            if (opcode == OP_BUTTON) led_in = button_state;
            if (opcode == OP_STARTUP || btn_hit) begin
               melody_sel_in = look_sel;
               note_pos_in   = 3'd0;
               tick_count_in = 16'd0;
               playing_in    = 1'b1;
               note_ticks_in = look_ticks;
               tone_in       = look_freq;
               timer_en_in   = 1'b1;
               load          = 1'b1;
            end
         end
         OP_TICK: begin
            if (playing_ff) begin
               tick_count_in = count_next;
               if (count_next == note_ticks_ff) begin
                  tick_count_in = 16'd0;
                  note_pos_in   = pos_next;
                  if (pos_next >= tune_len(melody_sel_ff)) begin
                     dac_in      = '0;
                     timer_en_in = 1'b0;
                     dac_en_in   = 1'b0;
                     playing_in  = 1'b0;
                  end else begin
                     note_ticks_in = look_ticks;
                     tone_in       = look_freq;
                     timer_en_in   = 1'b1;
                     load          = 1'b1;
                  end
               end else if (wave_high_next_ff) begin
                  dac_in            = DAC_HIGH;
                  wave_high_next_in = 1'b0;
               end else begin
                  dac_in            = '0;
                  wave_high_next_in = 1'b1;
               end
            end
         end
         default: load = 1'b0;
      endcase
   end

   assign result.led_pattern = led_in;
   assign result.dac_level   = dac_in;
   assign result.dac_on      = dac_en_in;
   assign result.timer_on    = timer_en_in;
   assign result.tone_freq   = tone_in;
   assign result.tone_load   = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         melody_sel_ff     <= '0;
         note_pos_ff       <= '0;
         tick_count_ff     <= '0;
         note_ticks_ff     <= '0;
         wave_high_next_ff <= 1'b1;
         playing_ff        <= 1'b0;
         led_ff            <= '0;
         dac_ff            <= '0;
         dac_en_ff         <= 1'b0;
         timer_en_ff       <= 1'b0;
         tone_ff           <= '0;
      end else if (step) begin
         melody_sel_ff     <= melody_sel_in;
         note_pos_ff       <= note_pos_in;
         tick_count_ff     <= tick_count_in;
         note_ticks_ff     <= note_ticks_in;
         wave_high_next_ff <= wave_high_next_in;
         playing_ff        <= playing_in;
         led_ff            <= led_in;
         dac_ff            <= dac_in;
         dac_en_ff         <= dac_en_in;
         timer_en_ff       <= timer_en_in;
         tone_ff           <= tone_in;
      end
   end

   a_timer_follows_play: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> timer_en_ff && dac_en_ff)
      else $error("timer or DAC off during playback");

   a_idle_timer_off: assert property (@(posedge clock) disable iff (reset)
      !playing_ff |-> !timer_en_ff)
      else $error("timer running while idle");

   a_target_nonzero: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> note_ticks_ff != 16'd0)
      else $error("zero tick target during playback");

   a_pos_in_tune: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> note_pos_ff < tune_len(melody_sel_ff))
      else $error("note position past end of tune");

endmodule

### src/button_triggered_tone_sequencer_top.sv
`timescale 1ns / 1ps

// Square-wave tune player. Takes one beat per clock on req_ and returns exactly
// one result beat per input beat on rsp_. An accepted beat waits in the input
// register, feeding the next player state logic (ROM lookup, tick compare and a
// single constant-reciprocal multiply), which loads the result register when the
// beat steps. A stall on rsp_ holds the result register and, once the input
// register is also full, raises req_stall; otherwise the sustained rate is one
// beat per cycle. Register writes on the APB port take effect at the access edge.

module button_triggered_tone_sequencer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic [7:0]                            req_button_state,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_led_pattern,
   output logic [11:0]                           rsp_dac_level,
   output logic                                  rsp_dac_on,
   output logic                                  rsp_timer_on,
   output logic [15:0]                           rsp_tone_freq,
   output logic                                  rsp_tone_load,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bttseq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bttseq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bttseq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                  pready
);
   import bttseq_pkg::*;

   cfg_type     cfg;
   rsp_type     next_rsp;
   rsp_type     rsp_ff;
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic [7:0]  in_btn_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        step;
   logic        req_take;

   bttseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   bttseq_player u_player (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .opcode       (in_op_ff),
      .button_state (in_btn_ff),
      .cfg          (cfg),
      .result       (next_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (step)            rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_opcode;
         in_btn_ff <= req_button_state;
      end
      if (step) rsp_ff <= next_rsp;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_pattern = rsp_ff.led_pattern;
   assign rsp_dac_level   = rsp_ff.dac_level;
   assign rsp_dac_on      = rsp_ff.dac_on;
   assign rsp_timer_on    = rsp_ff.timer_on;
   assign rsp_tone_freq   = rsp_ff.tone_freq;
   assign rsp_tone_load   = rsp_ff.tone_load;

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result beat without a held input beat");

   a_load_runs_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.tone_load |-> rsp_ff.timer_on)
      else $error("tone load with timer off");

   a_dac_off_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.dac_on |-> rsp_ff.dac_level == 12'd0)
      else $error("DAC level high while DAC disabled");

endmodule
